>>> rtl/saa_pkg.sv
package saa_pkg;

    localparam int P_W     = 17;
    localparam int T_W     = 16;
    localparam int CNT_W   = 7;
    localparam int PSUM_W  = 24;
    localparam int TSUM_W  = 23;
    localparam int DIV_W   = 24;
    localparam int REM_W   = CNT_W + 1;
    localparam int STEP_W  = 5;

    localparam logic [CNT_W-1:0]  COUNT_WRAP = 7'd127;
    localparam logic [CNT_W-1:0]  COUNT_HALF = 7'd64;
    localparam logic [STEP_W-1:0] DIV_LAST   = 5'd23;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic add;
        logic start;
        logic step;
        logic finish;
        logic stale;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic step_last;
    } t_status;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } t_div;

    // one restoring division step
    function automatic t_div div_step(input t_div cur, input logic [CNT_W-1:0] d);
        t_div             nxt;
        logic [REM_W-1:0] trial;
        trial   = {cur.rem[REM_W-2:0], cur.quo[DIV_W-1]};
        nxt.quo = {cur.quo[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
            nxt.rem    = trial - {1'b0, d};
            nxt.quo[0] = 1'b1;
        end else begin
            nxt.rem = trial;
        end
        return nxt;
    endfunction

endpackage

>>> rtl/saa_in_if.sv
interface saa_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [saa_pkg::P_W-1:0]      pressure_in;
    logic signed [saa_pkg::T_W-1:0] temperature_in;

    modport source (output valid, output opcode, output pressure_in,
                    output temperature_in, input ready);
    modport sink   (input valid, input opcode, input pressure_in,
                    input temperature_in, output ready);
endinterface

>>> rtl/saa_out_if.sv
interface saa_out_if;
    logic                           valid;
    logic                           ready;
    logic                           fresh;
    logic [saa_pkg::P_W-1:0]        pressure_avg;
    logic signed [saa_pkg::T_W-1:0] temperature_avg;
    logic [saa_pkg::CNT_W-1:0]      samples_used;
    logic                           healthy_flag;

    modport source (output valid, output fresh, output pressure_avg,
                    output temperature_avg, output samples_used,
                    output healthy_flag, input ready);
    modport sink   (input valid, input fresh, input pressure_avg,
                    input temperature_avg, input samples_used,
                    input healthy_flag, output ready);
endinterface

>>> rtl/sample_accumulate_average.sv
// Sample word: accepted with no result word; next word taken the cycle after.
// Read word with samples pending: the sums are loaded on acceptance, divided by the count
//   at one quotient bit per cycle, then stored; the result word is valid after the store.
// Read word with no samples pending: result word valid the cycle after acceptance.
// One word in flight; input is ready again the cycle after the result word is taken.
// Reset (synchronous, active low) clears sums, counts, stored averages and the health flag.
module sample_accumulate_average (
    input  logic      i_clk,
    input  logic      i_rst_n,
    saa_in_if.sink    i_in,
    saa_out_if.source o_out
);

    saa_pkg::t_cmd    cmd;
    saa_pkg::t_status status;

    saa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    saa_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_pressure        (i_in.pressure_in),
        .i_temperature     (i_in.temperature_in),
        .o_status          (status),
        .o_fresh           (o_out.fresh),
        .o_pressure_avg    (o_out.pressure_avg),
        .o_temperature_avg (o_out.temperature_avg),
        .o_samples_used    (o_out.samples_used),
        .o_healthy         (o_out.healthy_flag)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while result word pending");

    a_fresh_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.fresh) |-> (o_out.samples_used != '0))
        else $error("fresh result with zero sample count");

    a_healthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.opcode == saa_pkg::OP_SAMPLE))
        |=> o_out.healthy_flag)
        else $error("health flag not set after sample");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

endmodule

>>> rtl/saa_datapath.sv
module saa_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  saa_pkg::t_cmd                  i_cmd,
    input  logic [saa_pkg::P_W-1:0]        i_pressure,
    input  logic signed [saa_pkg::T_W-1:0] i_temperature,
    output saa_pkg::t_status               o_status,
    output logic                           o_fresh,
    output logic [saa_pkg::P_W-1:0]        o_pressure_avg,
    output logic signed [saa_pkg::T_W-1:0] o_temperature_avg,
    output logic [saa_pkg::CNT_W-1:0]      o_samples_used,
    output logic                           o_healthy
);

    logic [saa_pkg::PSUM_W-1:0]        r_psum;
    logic signed [saa_pkg::TSUM_W-1:0] r_tsum;
    logic [saa_pkg::CNT_W-1:0]         r_count;
    logic [saa_pkg::P_W-1:0]           r_pavg;
    logic signed [saa_pkg::T_W-1:0]    r_tavg;
    logic [saa_pkg::CNT_W-1:0]         r_cavg;
    logic                              r_healthy;
    logic                              r_fresh;

    saa_pkg::t_div                     r_pdiv;
    saa_pkg::t_div                     r_tdiv;
    logic                              r_tneg;
    logic [saa_pkg::STEP_W-1:0]        r_step;

    logic [saa_pkg::PSUM_W-1:0]        psum_add;
    logic signed [saa_pkg::TSUM_W-1:0] tsum_add;
    logic [saa_pkg::TSUM_W-1:0]        tsum_mag;
    logic [saa_pkg::T_W-1:0]           tq_mag;

    assign psum_add = r_psum + {{(saa_pkg::PSUM_W-saa_pkg::P_W){1'b0}}, i_pressure};
    assign tsum_add = r_tsum
                    + {{(saa_pkg::TSUM_W-saa_pkg::T_W){i_temperature[saa_pkg::T_W-1]}},
                       i_temperature};
    assign tsum_mag = r_tsum[saa_pkg::TSUM_W-1] ? (~r_tsum + 1'b1) : r_tsum;
    assign tq_mag   = r_tdiv.quo[saa_pkg::T_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum    <= '0;
            r_tsum    <= '0;
            r_count   <= '0;
            r_pavg    <= '0;
            r_tavg    <= '0;
            r_cavg    <= '0;
            r_healthy <= 1'b0;
            r_fresh   <= 1'b0;
        end else begin
            if (i_cmd.add) begin
                r_healthy <= 1'b1;
                if (r_count == saa_pkg::COUNT_WRAP) begin
                    r_count <= saa_pkg::COUNT_HALF;
                    r_psum  <= {1'b0, psum_add[saa_pkg::PSUM_W-1:1]};
                    r_tsum  <= {tsum_add[saa_pkg::TSUM_W-1], tsum_add[saa_pkg::TSUM_W-1:1]};
                end else begin
                    r_count <= r_count + 1'b1;
                    r_psum  <= psum_add;
                    r_tsum  <= tsum_add;
                end
            end
            if (i_cmd.stale) begin
                r_fresh <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_fresh <= 1'b1;
                r_pavg  <= r_pdiv.quo[saa_pkg::P_W-1:0];
                r_tavg  <= r_tneg ? (~tq_mag + 1'b1) : tq_mag;
                r_cavg  <= r_count;
                r_count <= '0;
                r_psum  <= '0;
                r_tsum  <= '0;
            end
        end
    end

    // shared-count long division, one quotient bit per cycle on both sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pdiv.rem <= '0;
            r_pdiv.quo <= r_psum;
            r_tdiv.rem <= '0;
            r_tdiv.quo <= {1'b0, tsum_mag};
            r_tneg     <= r_tsum[saa_pkg::TSUM_W-1];
            r_step     <= '0;
        end else if (i_cmd.step) begin
            r_pdiv <= saa_pkg::div_step(r_pdiv, r_count);
            r_tdiv <= saa_pkg::div_step(r_tdiv, r_count);
            r_step <= r_step + 1'b1;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.step_last  = (r_step == saa_pkg::DIV_LAST);

    assign o_fresh           = r_fresh;
    assign o_pressure_avg    = r_pavg;
    assign o_temperature_avg = r_tavg;
    assign o_samples_used    = r_cavg;
    assign o_healthy         = r_healthy;

endmodule

>>> rtl/saa_ctrl.sv
module saa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_opcode,
    input  logic             i_out_ready,
    input  saa_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output saa_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == saa_pkg::OP_SAMPLE) begin
                        o_cmd.add = 1'b1;
                    end else if (i_status.count_zero) begin
                        o_cmd.stale = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.step_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

endmodule

>>> test/tb_top.sv
module tb_top;

    localparam int P_W   = saa_pkg::P_W;
    localparam int T_W   = saa_pkg::T_W;
    localparam int CNT_W = saa_pkg::CNT_W;

    typedef struct packed {
        logic                  fresh;
        logic [P_W-1:0]        pressure;
        logic signed [T_W-1:0] temperature;
        logic [CNT_W-1:0]      count;
        logic                  healthy;
    } t_avg_word;

    // directed stimulus row; expected word is used only when typed is set
    typedef struct packed {
        logic                  op;
        logic [P_W-1:0]        p;
        logic signed [T_W-1:0] t;
        logic                  typed;
        t_avg_word             want;
    } t_dir_row;

    localparam int N_DIR = 23;
    localparam int PHASE_WORDS = 650;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // read right after reset: nothing stored, not healthy
        '{saa_pkg::OP_READ,   17'd0,     16'sd0,    1'b1,
          '{1'b0, 17'd0, 16'sd0, 7'd0, 1'b0}},
        // payload ignored on a read
        '{saa_pkg::OP_READ,   17'h1FFFF, 16'shFFFF, 1'b1,
          '{1'b0, 17'd0, 16'sd0, 7'd0, 1'b0}},
        '{saa_pkg::OP_SAMPLE, 17'h1FFFF, 16'sh8000, 1'b0, '0},
        '{saa_pkg::OP_READ,   17'd0,     16'sd0,    1'b1,
          '{1'b1, 17'h1FFFF, 16'sh8000, 7'd1, 1'b1}},
        // zero count: stored values repeat, not fresh
        '{saa_pkg::OP_READ,   17'd5,     16'sd9,    1'b1,
          '{1'b0, 17'h1FFFF, 16'sh8000, 7'd1, 1'b1}},
        '{saa_pkg::OP_SAMPLE, 17'd0,     16'sh7FFF, 1'b0, '0},
        '{saa_pkg::OP_READ,   17'd0,     16'sd0,    1'b1,
          '{1'b1, 17'd0, 16'sh7FFF, 7'd1, 1'b1}},
        // -7 / 2 truncates toward zero
        '{saa_pkg::OP_SAMPLE, 17'd1,     -16'sd3,   1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'd2,     -16'sd4,   1'b0, '0},
        '{saa_pkg::OP_READ,   17'd0,     16'sd0,    1'b1,
          '{1'b1, 17'd1, -16'sd3, 7'd2, 1'b1}},
        '{saa_pkg::OP_SAMPLE, 17'h1FFFF, 16'sh7FFF, 1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'h1FFFF, 16'sh7FFF, 1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'h1FFFE, 16'sh7FFE, 1'b0, '0},
        '{saa_pkg::OP_READ,   17'h1FFFF, 16'sh8000, 1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'd0,     -16'sd1,   1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'd0,     16'sd0,    1'b0, '0},
        '{saa_pkg::OP_READ,   17'd0,     16'sd0,    1'b1,
          '{1'b1, 17'd0, 16'sd0, 7'd2, 1'b1}},
        '{saa_pkg::OP_SAMPLE, 17'h10000, 16'sh8000, 1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'h0FFFF, 16'sh7FFF, 1'b0, '0},
        '{saa_pkg::OP_READ,   17'd0,     16'sd0,    1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'h15555, 16'sh5555, 1'b0, '0},
        '{saa_pkg::OP_SAMPLE, 17'h0AAAA, 16'shAAAA, 1'b0, '0},
        '{saa_pkg::OP_READ,   17'h0AAAA, 16'sh5555, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    saa_in_if  in_if();
    saa_out_if out_if();

    sample_accumulate_average u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // averager state as the predictor sees it
    int                    acc_p;
    int                    acc_t;
    int                    acc_n;
    logic [P_W-1:0]        held_p;
    logic signed [T_W-1:0] held_t;
    logic [CNT_W-1:0]      held_n;
    logic                  seen_sample;

    t_avg_word pending_averages[$];
    int        mismatch_count;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        phase_words;

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic advance_averager(input logic op, input logic [P_W-1:0] p,
                                    input logic signed [T_W-1:0] t,
                                    output bit has_word, output t_avg_word word);
        int q;
        has_word = 1'b0;
        word     = '0;
        if (op == saa_pkg::OP_SAMPLE) begin
            acc_n++;
            acc_p += int'(p);
            acc_t += int'(t);
            if (acc_n == 128) begin
                acc_n = 64;
                acc_p = acc_p >>> 1;
                acc_t = acc_t >>> 1;
            end
            seen_sample = 1'b1;
        end else begin
            word.fresh = 1'b0;
            if (acc_n != 0) begin
                word.fresh = 1'b1;
                q      = acc_p / acc_n;
                held_p = q[P_W-1:0];
                q      = acc_t / acc_n;
                held_t = q[T_W-1:0];
                held_n = acc_n[CNT_W-1:0];
                acc_n  = 0;
                acc_p  = 0;
                acc_t  = 0;
            end
            word.pressure    = held_p;
            word.temperature = held_t;
            word.count       = held_n;
            word.healthy     = seen_sample;
            has_word         = 1'b1;
        end
    endtask

    task automatic send_word(input logic op, input logic [P_W-1:0] p,
                             input logic signed [T_W-1:0] t,
                             input logic typed, input t_avg_word typed_word);
        bit        has_word;
        t_avg_word word;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.opcode         <= op;
        in_if.pressure_in    <= p;
        in_if.temperature_in <= t;
        do @(posedge i_clk); while (!in_if.ready);
        phase_words++;
        advance_averager(op, p, t, has_word, word);
        if (has_word) begin
            pending_averages.push_back(typed ? typed_word : word);
        end
    endtask

    function automatic logic [P_W-1:0] rand_pressure();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return P_W'($urandom_range(2**P_W - 1));
        endcase
    endfunction

    function automatic logic signed [T_W-1:0] rand_temperature();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return T_W'($urandom_range(2**T_W - 1));
        endcase
    endfunction

    task automatic send_burst(input int len, input logic fixed,
                              input logic [P_W-1:0] p, input logic signed [T_W-1:0] t);
        for (int i = 0; i < len; i++) begin
            if (fixed) begin
                send_word(saa_pkg::OP_SAMPLE, p, t, 1'b0, '0);
            end else begin
                send_word(saa_pkg::OP_SAMPLE, rand_pressure(), rand_temperature(), 1'b0, '0);
            end
        end
        send_word(saa_pkg::OP_READ, rand_pressure(), rand_temperature(), 1'b0, '0);
    endtask

    // result side: random back-pressure
    initial begin
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_avg_word got;
        t_avg_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.fresh       = out_if.fresh;
            got.pressure    = out_if.pressure_avg;
            got.temperature = out_if.temperature_avg;
            got.count       = out_if.samples_used;
            got.healthy     = out_if.healthy_flag;
            if (pending_averages.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = pending_averages.pop_front();
                if (got.fresh !== want.fresh)
                    report_mismatch($sformatf("fresh %b, expected %b",
                                              got.fresh, want.fresh));
                if (got.pressure !== want.pressure)
                    report_mismatch($sformatf("pressure_avg %0d, expected %0d",
                                              got.pressure, want.pressure));
                if (got.temperature !== want.temperature)
                    report_mismatch($sformatf("temperature_avg %0d, expected %0d",
                                              got.temperature, want.temperature));
                if (got.count !== want.count)
                    report_mismatch($sformatf("samples_used %0d, expected %0d",
                                              got.count, want.count));
                if (got.healthy !== want.healthy)
                    report_mismatch($sformatf("healthy_flag %b, expected %b",
                                              got.healthy, want.healthy));
            end
        end
    end

    initial begin
        int kind;
        int len;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.opcode         = saa_pkg::OP_SAMPLE;
        in_if.pressure_in    = '0;
        in_if.temperature_in = '0;
        acc_p          = 0;
        acc_t          = 0;
        acc_n          = 0;
        held_p         = '0;
        held_t         = '0;
        held_n         = '0;
        seen_sample    = 1'b0;
        mismatch_count = 0;
        tx_idle_pct    = 13;
        rx_idle_pct    = 63;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 13; rx_idle_pct = 63; end
                1: begin tx_idle_pct = 63; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            phase_words = 0;
            if (ph == 0) begin
                for (int r = 0; r < N_DIR; r++) begin
                    send_word(DIR_ROWS[r].op, DIR_ROWS[r].p, DIR_ROWS[r].t,
                              DIR_ROWS[r].typed, DIR_ROWS[r].want);
                end
                // fill to just below the halving point, then through it
                send_burst(127, 1'b1, 17'h1FFFF, 16'sh8000);
                send_burst(128, 1'b1, 17'h1FFFF, 16'sh8000);
                send_burst(129, 1'b1, 17'h1FFFF, 16'sh7FFF);
            end
            while (phase_words < PHASE_WORDS) begin
                kind = $urandom_range(99);
                if (kind < 8)
                    len = 0;
                else if (kind < 60)
                    len = $urandom_range(8, 1);
                else if (kind < 88)
                    len = $urandom_range(60, 9);
                else
                    len = $urandom_range(260, 100);
                send_burst(len, 1'b0, '0, '0);
            end
            // hold off until every result has drained
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            while (pending_averages.size() != 0) @(posedge i_clk);
        end

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sample_accumulate_average.f
rtl/saa_pkg.sv
rtl/saa_in_if.sv
rtl/saa_out_if.sv
rtl/saa_datapath.sv
rtl/saa_ctrl.sv
rtl/sample_accumulate_average.sv
test/tb_top.sv
